>>> rtl/fwrdm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwrdm_pkg: shared types and codes for the four-wheel drive mixer
// field widths, command and direction codes, register indexes
// ----------------------------------------------------------------------------
package fwrdm_pkg;

    localparam int DUTY_W  = 12;
    localparam int DIR_W   = 2;
    localparam int SPEED_W = 13;
    localparam int WHEEL_W = 15;  // holds fs + corr and its negation
    localparam int REQ_W   = 2;
    localparam int CFG_W   = 12;
    localparam int CFG_IDX_W = 2;
    localparam int INV_W   = 4;

    // command kinds
    localparam logic [REQ_W-1:0] REQ_SOFT_STOP = 2'd0;
    localparam logic [REQ_W-1:0] REQ_BRAKE     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SPIN      = 2'd2;
    localparam logic [REQ_W-1:0] REQ_ADVANCE   = 2'd3;

    // direction codes
    localparam logic [DIR_W-1:0] DIR_STOP    = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FORWARD = 2'd1;
    localparam logic [DIR_W-1:0] DIR_REVERSE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_INVERT = 2'd2;

    // wheel invert bit positions
    localparam int FL_BIT = 0;
    localparam int FR_BIT = 1;
    localparam int RL_BIT = 2;
    localparam int RR_BIT = 3;

    typedef struct packed {
        logic [REQ_W-1:0]          req;
        logic signed [SPEED_W-1:0] speed;
        logic signed [SPEED_W-1:0] correction;
    } t_cmd;

endpackage

>>> rtl/fwrdm_ramp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwrdm_ramp: ramped forward speed and side mixing
// holds the forward speed, updates it per command, forms left/right values
// ----------------------------------------------------------------------------
module fwrdm_ramp
    import fwrdm_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_fire,
    input  t_cmd                      i_cmd,
    input  logic [CFG_W-1:0]          i_ramp_step,
    output logic signed [WHEEL_W-1:0] o_left,
    output logic signed [WHEEL_W-1:0] o_right,
    output logic signed [SPEED_W-1:0] o_next_speed
);

    logic signed [SPEED_W-1:0] r_fwd_speed;
    logic signed [SPEED_W-1:0] n_fwd_speed;

    logic signed [WHEEL_W-1:0] fs_w;
    logic signed [WHEEL_W-1:0] step_w;
    logic signed [WHEEL_W-1:0] spd_w;
    logic signed [WHEEL_W-1:0] corr_w;
    logic signed [WHEEL_W-1:0] dec_w;
    logic signed [WHEEL_W-1:0] inc_w;
    logic signed [WHEEL_W-1:0] adv_w;
    logic signed [WHEEL_W-1:0] next_w;

    assign fs_w   = WHEEL_W'(r_fwd_speed);
    assign step_w = $signed({{(WHEEL_W-CFG_W){1'b0}}, i_ramp_step});
    assign spd_w  = WHEEL_W'(i_cmd.speed);
    assign corr_w = WHEEL_W'(i_cmd.correction);
    assign dec_w  = fs_w - step_w;
    assign inc_w  = fs_w + step_w;

    always_comb begin
        next_w  = fs_w;
        adv_w   = fs_w;
        o_left  = '0;
        o_right = '0;
        unique case (i_cmd.req)
            REQ_SOFT_STOP: begin
                // ramp toward zero without crossing it
                if (fs_w > 0) begin
                    next_w = (dec_w < 0) ? '0 : dec_w;
                end else if (fs_w < 0) begin
                    next_w = (inc_w > 0) ? '0 : inc_w;
                end
                o_left  = next_w;
                o_right = next_w;
            end
            REQ_BRAKE: begin
                next_w = '0;
            end
            REQ_SPIN: begin
                o_left  = spd_w;
                o_right = -spd_w;
            end
            default: begin
                // advance: step up, snap down to target
                adv_w   = (fs_w < spd_w) ? inc_w : fs_w;
                next_w  = (adv_w > spd_w) ? spd_w : adv_w;
                o_left  = next_w + corr_w;
                o_right = next_w - corr_w;
            end
        endcase
    end

    assign n_fwd_speed  = next_w[SPEED_W-1:0];
    assign o_next_speed = n_fwd_speed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_speed <= '0;
        end else if (i_fire) begin
            r_fwd_speed <= n_fwd_speed;
        end
    end

endmodule

>>> rtl/fwrdm_wheel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwrdm_wheel: per-wheel invert, saturate and duty/direction encode
// turns a signed wheel value into a duty magnitude and a direction code
// ----------------------------------------------------------------------------
module fwrdm_wheel
    import fwrdm_pkg::*;
(
    input  logic signed [WHEEL_W-1:0] i_value,
    input  logic                      i_invert,
    input  logic [CFG_W-1:0]          i_limit,
    output logic [DUTY_W-1:0]         o_duty,
    output logic [DIR_W-1:0]          o_dir
);

    logic signed [WHEEL_W-1:0] v_inv;
    logic signed [WHEEL_W-1:0] lim_w;
    logic signed [WHEEL_W-1:0] v_sat;
    logic signed [WHEEL_W-1:0] v_abs;

    assign v_inv = i_invert ? -i_value : i_value;
    assign lim_w = $signed({{(WHEEL_W-CFG_W){1'b0}}, i_limit});

    always_comb begin
        if (v_inv > lim_w) begin
            v_sat = lim_w;
        end else if (v_inv < -lim_w) begin
            v_sat = -lim_w;
        end else begin
            v_sat = v_inv;
        end
    end

    assign v_abs  = v_sat[WHEEL_W-1] ? -v_sat : v_sat;
    assign o_duty = v_abs[DUTY_W-1:0];

    always_comb begin
        if (v_sat > 0) begin
            o_dir = DIR_FORWARD;
        end else if (v_sat < 0) begin
            o_dir = DIR_REVERSE;
        end else begin
            o_dir = DIR_STOP;
        end
    end

endmodule

>>> rtl/four_wheel_ramped_drive_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_wheel_ramped_drive_mixer: ramped four-wheel drive mixer
// one command item in, one item of four wheel duties/directions out
// ----------------------------------------------------------------------------
//
// channel   dir  tdata fields (low bit up)                         tuser
// -------   ---  ------------------------------------------------  --------
// s_axis    in   speed[12:0], correction[25:13], pad to 32          req_type
// m_axis    out  fl duty/dir, fr duty/dir, rl duty/dir,             -
//                rr duty/dir (12+2 each), ramp_speed, pad to 72
// cfg       in   i_cfg_we, i_cfg_idx, i_cfg_data (12 bit)           -
//
// two register stages: input register, then result register; the speed
// update and all four wheel paths sit between them, so one item per cycle
// flows through while m_axis does not stall, and an item's result is offered
// from the result register; synchronous active-low reset clears both valid
// flags and the ramp speed; config registers reset to limit 255, step 5,
// no inversion; a stall on m_axis holds the result register and backs up into
// the input register; s_axis_tready drops only when both stages are full and stalled
// ----------------------------------------------------------------------------
module four_wheel_ramped_drive_mixer
    import fwrdm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command input
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,   // speed[12:0], correction[25:13]
    input  logic [REQ_W-1:0]     s_axis_tuser,   // req_type[1:0]
    // result output
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [71:0]          m_axis_tdata,   // fl_duty, fl_dir, fr_duty, fr_dir,
                                                 // rl_duty, rl_dir, rr_duty, rr_dir,
                                                 // ramp_speed[68:56]
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // config registers
    logic [CFG_W-1:0] r_pwm_limit;
    logic [CFG_W-1:0] r_ramp_step;
    logic [INV_W-1:0] r_wheel_invert;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_limit    <= CFG_W'(255);
            r_ramp_step    <= CFG_W'(5);
            r_wheel_invert <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PWM_LIMIT:    r_pwm_limit    <= i_cfg_data;
                CFG_RAMP_STEP:    r_ramp_step    <= i_cfg_data;
                CFG_WHEEL_INVERT: r_wheel_invert <= i_cfg_data[INV_W-1:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // pipeline control
    logic r_in_valid;
    logic r_out_valid;
    logic out_free;
    logic fire;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign m_axis_tvalid = r_out_valid;

    // input register
    t_cmd r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_cmd.req        <= s_axis_tuser;
            r_cmd.speed      <= s_axis_tdata[SPEED_W-1:0];
            r_cmd.correction <= s_axis_tdata[2*SPEED_W-1:SPEED_W];
        end
    end

    // speed ramp and side mixing; state advances as the item moves on
    logic signed [WHEEL_W-1:0] left_val;
    logic signed [WHEEL_W-1:0] right_val;
    logic signed [SPEED_W-1:0] next_speed;

    fwrdm_ramp u_ramp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_cmd        (r_cmd),
        .i_ramp_step  (r_ramp_step),
        .o_left       (left_val),
        .o_right      (right_val),
        .o_next_speed (next_speed)
    );

    // four wheel encoders, left values to left wheels
    logic [DUTY_W-1:0] fl_duty, fr_duty, rl_duty, rr_duty;
    logic [DIR_W-1:0]  fl_dir, fr_dir, rl_dir, rr_dir;

    fwrdm_wheel u_fl (
        .i_value  (left_val),
        .i_invert (r_wheel_invert[FL_BIT]),
        .i_limit  (r_pwm_limit),
        .o_duty   (fl_duty),
        .o_dir    (fl_dir)
    );

    fwrdm_wheel u_fr (
        .i_value  (right_val),
        .i_invert (r_wheel_invert[FR_BIT]),
        .i_limit  (r_pwm_limit),
        .o_duty   (fr_duty),
        .o_dir    (fr_dir)
    );

    fwrdm_wheel u_rl (
        .i_value  (left_val),
        .i_invert (r_wheel_invert[RL_BIT]),
        .i_limit  (r_pwm_limit),
        .o_duty   (rl_duty),
        .o_dir    (rl_dir)
    );

    fwrdm_wheel u_rr (
        .i_value  (right_val),
        .i_invert (r_wheel_invert[RR_BIT]),
        .i_limit  (r_pwm_limit),
        .o_duty   (rr_duty),
        .o_dir    (rr_dir)
    );

    // result register
    logic [71:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= {3'b000, next_speed,
                           rr_dir, rr_duty, rl_dir, rl_duty,
                           fr_dir, fr_duty, fl_dir, fl_duty};
        end
    end

    assign m_axis_tdata = r_out_data;

endmodule
